@@ hw/rtl/bdeq_pkg.sv @@
// Package for the bounded double-ended queue: sizes, codes, types and the ring helper.
package bdeq_pkg;

   // Store size and the index and count widths derived from it.
   localparam int DEPTH = 32;
   localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam int ELEM_W = 32;

   typedef logic [IDX_W-1:0] idx_type;
   typedef logic [CNT_W-1:0] cnt_type;
   typedef logic signed [ELEM_W-1:0] elem_type;
   typedef logic [2:0] cmd_code_type;
   typedef logic [2:0] status_type;
   typedef logic [1:0] rd_mode_type;

   // Command codes carried by an input item.
   localparam cmd_code_type CMD_PUSH_FRONT = 3'd0;
   localparam cmd_code_type CMD_PUSH_BACK  = 3'd1;
   localparam cmd_code_type CMD_POP_FRONT  = 3'd2;
   localparam cmd_code_type CMD_POP_BACK   = 3'd3;
   localparam cmd_code_type CMD_LIST_FWD   = 3'd4;
   localparam cmd_code_type CMD_LIST_BWD   = 3'd5;

   // Status codes carried by a result item.
   localparam status_type ST_PUSHED = 3'd0;
   localparam status_type ST_POPPED = 3'd1;
   localparam status_type ST_LISTED = 3'd2;
   localparam status_type ST_EMPTY  = 3'd3;
   localparam status_type ST_FULL   = 3'd4;

   // Where the datapath takes its read address from.
   localparam rd_mode_type RD_FRONT   = 2'd0;
   localparam rd_mode_type RD_BACK    = 2'd1;
   localparam rd_mode_type RD_FWD_CNT = 2'd2;
   localparam rd_mode_type RD_BWD_CNT = 2'd3;

   // Commands from the controller to the datapath for one cycle.
   typedef struct packed {
      logic        issue;       // load one result into the read stage
      status_type  res_status;
      logic        res_last;
      logic        from_ram;    // result element comes from the store
      rd_mode_type rd_mode;
      logic        push_front;
      logic        push_back;
      logic        pop_front;
      logic        pop_back;
      logic        list_start;
      logic        list_step;
   } dp_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic empty;
      logic full;
      logic one_left;
      logic list_last;
      logic stage_free;
   } dp_stat_type;

   // Adds two ring positions modulo DEPTH; both operands are below DEPTH.
   function automatic idx_type ring_add(idx_type a, idx_type b);
      logic [IDX_W:0] sum;
      sum = {1'b0, a} + {1'b0, b};
      if (sum >= (IDX_W + 1)'(DEPTH)) begin
         sum = sum - (IDX_W + 1)'(DEPTH);
      end
      return sum[IDX_W-1:0];
   endfunction

endpackage

@@ hw/rtl/bdeq_req_if.sv @@
// Request channel interface: valid/ready handshake with command and value.
interface bdeq_req_if;
   logic                  valid;
   logic                  ready;
   bdeq_pkg::cmd_code_type command;
   bdeq_pkg::elem_type     value;

   modport source (output valid, output command, output value, input ready);
   modport sink (input valid, input command, input value, output ready);
endinterface

@@ hw/rtl/bdeq_rsp_if.sv @@
// Response channel interface: valid/ready handshake with status, element and last.
interface bdeq_rsp_if;
   logic                 valid;
   logic                 ready;
   bdeq_pkg::status_type status;
   bdeq_pkg::elem_type   element;
   logic                 last;

   modport source (output valid, output status, output element, output last, input ready);
   modport sink (input valid, input status, input element, input last, output ready);
endinterface

@@ hw/rtl/bounded_double_ended_queue.sv @@
// Top level of the bounded double-ended queue: controller plus datapath.
//
//   channel   direction   carries
//   req_ch    in          command, value
//   rsp_ch    out         status, element, last
//
// For a push or pop, the result passes through the read stage and the output register to rsp_ch.
// A listing of N elements streams one result per cycle while the read stage is not stalled, from the single
// read port of the element store; no item is accepted until its last read is issued.
// Reset clears the front index, the occupancy and all pipeline valid flags.
// A stalled result holds the read stage, which in turn holds off input items.
module bounded_double_ended_queue (
   input logic         clock,
   input logic         reset,
   bdeq_req_if.sink    req_ch,
   bdeq_rsp_if.source  rsp_ch
);

   bdeq_pkg::dp_cmd_type  cmd;
   bdeq_pkg::dp_stat_type stat;
   logic                  ready;

   assign req_ch.ready = ready;

   bdeq_ctrl u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_ch.valid),
      .req_command (req_ch.command),
      .req_ready   (ready),
      .stat        (stat),
      .cmd         (cmd)
   );

   bdeq_dp u_dp (
      .clock     (clock),
      .reset     (reset),
      .req_value (req_ch.value),
      .cmd       (cmd),
      .stat      (stat),
      .rsp_ch    (rsp_ch)
   );

endmodule

@@ hw/rtl/bdeq_ram.sv @@
// Generic single-write, single-read RAM with a registered read port.
module bdeq_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 32
) (
   input  logic                                    clock,
   input  logic                                    wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                        wr_data,
   input  logic                                    rd_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                        rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // Read port; the data register holds while no read is enabled.
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ hw/rtl/bdeq_ctrl.sv @@
// Controller state machine: accepts items, decodes commands and sequences listings.
module bdeq_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   input  bdeq_pkg::cmd_code_type req_command,
   output logic                   req_ready,
   input  bdeq_pkg::dp_stat_type  stat,
   output bdeq_pkg::dp_cmd_type   cmd
);

   localparam logic [1:0] S_IDLE     = 2'd0;
   localparam logic [1:0] S_LIST_FWD = 2'd1;
   localparam logic [1:0] S_LIST_BWD = 2'd2;

   logic [1:0] state_ff;
   logic [1:0] state_in;
   logic       accept;

   // A new item is taken only between listings and when the read stage can move.
   assign req_ready = (state_ff == S_IDLE) && stat.stage_free;
   assign accept    = req_valid && req_ready;

   // Command decode and listing sequence.
   always_comb begin
      cmd      = '0;
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               unique case (req_command)
                  bdeq_pkg::CMD_PUSH_FRONT, bdeq_pkg::CMD_PUSH_BACK: begin
                     cmd.issue    = 1'b1;
                     cmd.res_last = 1'b1;
                     if (stat.full) begin
                        cmd.res_status = bdeq_pkg::ST_FULL;
                     end else begin
                        cmd.res_status = bdeq_pkg::ST_PUSHED;
                        cmd.push_front = (req_command == bdeq_pkg::CMD_PUSH_FRONT);
                        cmd.push_back  = (req_command == bdeq_pkg::CMD_PUSH_BACK);
                     end
                  end
                  bdeq_pkg::CMD_POP_FRONT, bdeq_pkg::CMD_POP_BACK: begin
                     cmd.issue    = 1'b1;
                     cmd.res_last = 1'b1;
                     if (stat.empty) begin
                        cmd.res_status = bdeq_pkg::ST_EMPTY;
                     end else begin
                        cmd.res_status = bdeq_pkg::ST_POPPED;
                        cmd.from_ram   = 1'b1;
                        if (req_command == bdeq_pkg::CMD_POP_FRONT) begin
                           cmd.rd_mode   = bdeq_pkg::RD_FRONT;
                           cmd.pop_front = 1'b1;
                        end else begin
                           cmd.rd_mode  = bdeq_pkg::RD_BACK;
                           cmd.pop_back = 1'b1;
                        end
                     end
                  end
                  bdeq_pkg::CMD_LIST_FWD, bdeq_pkg::CMD_LIST_BWD: begin
                     cmd.issue = 1'b1;
                     if (stat.empty) begin
                        cmd.res_status = bdeq_pkg::ST_EMPTY;
                        cmd.res_last   = 1'b1;
                     end else begin
                        // The first element goes out now; the rest follow from the count.
                        cmd.res_status = bdeq_pkg::ST_LISTED;
                        cmd.from_ram   = 1'b1;
                        cmd.res_last   = stat.one_left;
                        if (req_command == bdeq_pkg::CMD_LIST_FWD) begin
                           cmd.rd_mode = bdeq_pkg::RD_FRONT;
                        end else begin
                           cmd.rd_mode = bdeq_pkg::RD_BACK;
                        end
                        if (!stat.one_left) begin
                           cmd.list_start = 1'b1;
                           state_in = (req_command == bdeq_pkg::CMD_LIST_FWD) ?
                                      S_LIST_FWD : S_LIST_BWD;
                        end
                     end
                  end
                  default: begin
                     // Unknown commands are dropped without a result.
                  end
               endcase
            end
         end
         S_LIST_FWD, S_LIST_BWD: begin
            if (stat.stage_free) begin
               cmd.issue      = 1'b1;
               cmd.res_status = bdeq_pkg::ST_LISTED;
               cmd.from_ram   = 1'b1;
               cmd.res_last   = stat.list_last;
               cmd.list_step  = 1'b1;
               cmd.rd_mode    = (state_ff == S_LIST_FWD) ?
                                bdeq_pkg::RD_FWD_CNT : bdeq_pkg::RD_BWD_CNT;
               if (stat.list_last) begin
                  state_in = S_IDLE;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // State register.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

@@ hw/rtl/bdeq_dp.sv @@
// Datapath: ring pointers, element store, read stage and output register.
module bdeq_dp (
   input  logic                  clock,
   input  logic                  reset,
   input  bdeq_pkg::elem_type    req_value,
   input  bdeq_pkg::dp_cmd_type  cmd,
   output bdeq_pkg::dp_stat_type stat,
   bdeq_rsp_if.source            rsp_ch
);

   bdeq_pkg::idx_type    front_ff, front_in;
   bdeq_pkg::cnt_type    occ_ff, occ_in;
   bdeq_pkg::idx_type    cnt_ff, cnt_in;
   bdeq_pkg::cnt_type    occ_minus1;
   bdeq_pkg::idx_type    back_off;
   bdeq_pkg::idx_type    front_prev;
   bdeq_pkg::idx_type    rd_addr;
   bdeq_pkg::idx_type    wr_addr;
   logic                 wr_en;
   logic                 rd_en;
   logic [bdeq_pkg::ELEM_W-1:0] rd_data;

   logic                 d_valid_ff, d_valid_in;
   bdeq_pkg::status_type d_status_ff;
   logic                 d_last_ff;
   logic                 d_ram_ff;
   logic                 out_free;
   logic                 consumed;

   logic                 out_valid_ff, out_valid_in;
   bdeq_pkg::status_type out_status_ff;
   bdeq_pkg::elem_type   out_element_ff;
   logic                 out_last_ff;

   // Offsets of the back element and of the slot in front of the front.
   assign occ_minus1 = occ_ff - bdeq_pkg::CNT_W'(1);
   assign back_off   = occ_minus1[bdeq_pkg::IDX_W-1:0];
   assign front_prev = bdeq_pkg::ring_add(front_ff, bdeq_pkg::IDX_W'(bdeq_pkg::DEPTH - 1));

   // Read address selection.
   always_comb begin
      unique case (cmd.rd_mode)
         bdeq_pkg::RD_FRONT:   rd_addr = front_ff;
         bdeq_pkg::RD_BACK:    rd_addr = bdeq_pkg::ring_add(front_ff, back_off);
         bdeq_pkg::RD_FWD_CNT: rd_addr = bdeq_pkg::ring_add(front_ff, cnt_ff);
         bdeq_pkg::RD_BWD_CNT: rd_addr = bdeq_pkg::ring_add(front_ff, back_off - cnt_ff);
         default:              rd_addr = front_ff;
      endcase
   end

   // Write address: new front slot or the slot just past the back.
   assign wr_en   = cmd.push_front || cmd.push_back;
   assign wr_addr = cmd.push_front ? front_prev :
                    bdeq_pkg::ring_add(front_ff, occ_ff[bdeq_pkg::IDX_W-1:0]);
   assign rd_en   = cmd.issue && cmd.from_ram;

   bdeq_ram #(
      .WIDTH (bdeq_pkg::ELEM_W),
      .DEPTH (bdeq_pkg::DEPTH)
   ) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (req_value),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // Pointer and listing counter updates.
   always_comb begin
      front_in = front_ff;
      occ_in   = occ_ff;
      cnt_in   = cnt_ff;
      if (cmd.push_front) begin
         front_in = front_prev;
      end
      if (cmd.pop_front) begin
         front_in = bdeq_pkg::ring_add(front_ff, bdeq_pkg::IDX_W'(1));
      end
      if (cmd.push_front || cmd.push_back) begin
         occ_in = occ_ff + bdeq_pkg::CNT_W'(1);
      end
      if (cmd.pop_front || cmd.pop_back) begin
         occ_in = occ_minus1;
      end
      if (cmd.list_start) begin
         cnt_in = bdeq_pkg::IDX_W'(1);
      end else if (cmd.list_step) begin
         cnt_in = cnt_ff + bdeq_pkg::IDX_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         front_ff <= '0;
         occ_ff   <= '0;
         cnt_ff   <= '0;
      end else begin
         front_ff <= front_in;
         occ_ff   <= occ_in;
         cnt_ff   <= cnt_in;
      end
   end

   // The read stage moves into the output register when that register is free or drains.
   assign out_free   = !out_valid_ff || rsp_ch.ready;
   assign consumed   = d_valid_ff && out_free;
   assign d_valid_in = cmd.issue ? 1'b1 : (consumed ? 1'b0 : d_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         d_valid_ff <= 1'b0;
      end else begin
         d_valid_ff <= d_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.issue) begin
         d_status_ff <= cmd.res_status;
         d_last_ff   <= cmd.res_last;
         d_ram_ff    <= cmd.from_ram;
      end
   end

   // Output register.
   assign out_valid_in = consumed ? 1'b1 : (rsp_ch.ready ? 1'b0 : out_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (consumed) begin
         out_status_ff  <= d_status_ff;
         out_element_ff <= d_ram_ff ? bdeq_pkg::elem_type'(rd_data) : '0;
         out_last_ff    <= d_last_ff;
      end
   end

   assign rsp_ch.valid   = out_valid_ff;
   assign rsp_ch.status  = out_status_ff;
   assign rsp_ch.element = out_element_ff;
   assign rsp_ch.last    = out_last_ff;

   // Status toward the controller.
   assign stat.empty      = (occ_ff == '0);
   assign stat.full       = (occ_ff == bdeq_pkg::CNT_W'(bdeq_pkg::DEPTH));
   assign stat.one_left   = (occ_ff == bdeq_pkg::CNT_W'(1));
   assign stat.list_last  = (cnt_ff == back_off);
   assign stat.stage_free = !d_valid_ff || out_free;

endmodule

@@ hw/rtl/bdeq_checker.sv @@
// Port-level checker for the bounded double-ended queue and its bind.
module bdeq_checker (
   input logic                 clock,
   input logic                 reset,
   input logic                 rsp_valid,
   input logic                 rsp_ready,
   input bdeq_pkg::status_type rsp_status,
   input bdeq_pkg::elem_type   rsp_element,
   input logic                 rsp_last
);

   // A result waiting on the port stays there.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("result dropped while stalled");

   // A stalled result keeps its payload.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> $stable(rsp_status) && $stable(rsp_element)
                                  && $stable(rsp_last))
      else $error("result changed while stalled");

   // Only pops and listings carry an element.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status != bdeq_pkg::ST_POPPED && rsp_status != bdeq_pkg::ST_LISTED
      |-> rsp_element == '0)
      else $error("element not zero for a status without one");

   // Every result other than a listed element ends its item.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status != bdeq_pkg::ST_LISTED |-> rsp_last)
      else $error("single result without last");

endmodule

bind bounded_double_ended_queue bdeq_checker u_bdeq_checker (
   .clock       (clock),
   .reset       (reset),
   .rsp_valid   (rsp_ch.valid),
   .rsp_ready   (rsp_ch.ready),
   .rsp_status  (rsp_ch.status),
   .rsp_element (rsp_ch.element),
   .rsp_last    (rsp_ch.last)
);
